>>> design/rtc_pkg.sv
package rtc_pkg;

  localparam int CharW      = 8;
  localparam int BaseW      = 6;
  localparam int DigitW     = 6;
  localparam int StackDepth = 32;
  localparam int StackAddrW = 5;
  localparam int QueueDepth = 4;
  localparam int QueueAddrW = 2;

  localparam logic [BaseW-1:0] BASE_MIN   = 6'd2;
  localparam logic [BaseW-1:0] BASE_MAX   = 6'd36;
  localparam logic [BaseW-1:0] BASE_RESET = 6'd10;

  localparam logic REG_SOURCE_BASE = 1'b0;
  localparam logic REG_TARGET_BASE = 1'b1;

  localparam logic [CharW-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CharW-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CharW-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CharW-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CharW-1:0] CHAR_LOWER_Z = 8'h7A;

  typedef struct packed {
    logic              is_final;
    logic [DigitW-1:0] digit;
  } rtc_entry_t;

  function automatic logic [DigitW-1:0] char_value(input logic [CharW-1:0] c);
    logic [CharW-1:0] diff;
    diff = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff = c - CHAR_ZERO;
      return diff[DigitW-1:0];
    end
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      diff = c - CHAR_LOWER_A + 8'd10;
      return diff[DigitW-1:0];
    end
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      diff = c - CHAR_UPPER_A + 8'd10;
      return diff[DigitW-1:0];
    end
    return '0;
  endfunction

  function automatic logic [CharW-1:0] value_char(input logic [DigitW-1:0] d);
    if (d <= 6'd9) begin
      return CHAR_ZERO + {2'b00, d};
    end
    return CHAR_UPPER_A + {2'b00, d} - 8'd10;
  endfunction

  function automatic logic [BaseW-1:0] clamp_base(input logic [BaseW-1:0] b);
    if (b < BASE_MIN) begin
      return BASE_MIN;
    end
    if (b > BASE_MAX) begin
      return BASE_MAX;
    end
    return b;
  endfunction

endpackage

>>> design/rtc_front.sv
module rtc_front (
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,
  input  logic                      s_tlast,
  input  logic                      queue_full,
  output logic                      push,
  output rtc_pkg::rtc_entry_t       push_data
);
  import rtc_pkg::*;

  // Characters are decoded to digit values on the way in, so the back end
  // only ever sees a digit and a final flag.
  assign s_tready           = !queue_full;
  assign push               = s_tvalid && !queue_full;
  assign push_data.digit    = char_value(s_tdata);
  assign push_data.is_final = s_tlast;

endmodule

>>> design/rtc_fifo.sv
module rtc_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rtc_pkg::rtc_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output rtc_pkg::rtc_entry_t pop_data,
  output logic                empty
);
  import rtc_pkg::*;

  rtc_entry_t            slots [QueueDepth];
  logic [QueueAddrW-1:0] wr_ptr;
  logic [QueueAddrW-1:0] rd_ptr;
  logic [QueueAddrW:0]   count;

  assign full     = (count == (QueueAddrW+1)'(QueueDepth));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/rtc_back.sv
module rtc_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [5:0]          in_base,
  input  logic [5:0]          tgt_base,
  input  logic                queue_empty,
  input  rtc_pkg::rtc_entry_t entry,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast
);
  import rtc_pkg::*;

  localparam int CntW = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_PUSH = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_LOAD = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;

  logic [2:0]            state;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;
  logic [VALUE_BITS-1:0] quot;
  logic [DigitW-1:0]     rem;
  logic [CntW-1:0]       bit_cnt;
  logic [StackAddrW:0]   n;
  logic [StackAddrW-1:0] idx;
  logic [DigitW-1:0]     stack [StackDepth];
  logic [DigitW-1:0]     rd_q;
  logic                  stack_we;
  logic [DigitW:0]       trial;
  logic                  ge;
  logic [DigitW:0]       trial_sub;

  assign acc_next  = acc * VALUE_BITS'(in_base) + VALUE_BITS'(entry.digit);
  assign pop       = (state == ST_IDLE) && !queue_empty;

  // One restoring step: shift the next dividend bit into the remainder.
  assign trial     = {rem, quot[VALUE_BITS-1]};
  assign ge        = (trial >= {1'b0, tgt_base});
  assign trial_sub = trial - {1'b0, tgt_base};

  // Digits beyond the stack depth are the most significant ones and are dropped.
  assign stack_we  = (state == ST_PUSH) && (n < (StackAddrW+1)'(StackDepth));

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack[n[StackAddrW-1:0]] <= rem;
    end
    if (state == ST_READ) begin
      rd_q <= stack[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      acc      <= '0;
      n        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!queue_empty) begin
            if (entry.is_final) begin
              quot    <= acc_next;
              acc     <= '0;
              rem     <= '0;
              bit_cnt <= '0;
              n       <= '0;
              state   <= ST_DIV;
            end else begin
              acc <= acc_next;
            end
          end
        end
        ST_DIV: begin
          rem     <= ge ? trial_sub[DigitW-1:0] : trial[DigitW-1:0];
          quot    <= {quot[VALUE_BITS-2:0], ge};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == CntW'(VALUE_BITS - 1)) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (stack_we) begin
            n <= n + 1'b1;
          end
          if (quot == '0) begin
            idx   <= stack_we ? n[StackAddrW-1:0] : n[StackAddrW-1:0] - 1'b1;
            state <= ST_READ;
          end else begin
            rem     <= '0;
            bit_cnt <= '0;
            state   <= ST_DIV;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          m_tdata  <= value_char(rd_q);
          m_tlast  <= (idx == '0);
          m_tvalid <= 1'b1;
          state    <= ST_WAIT;
        end
        ST_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (idx == '0) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx - 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= (StackAddrW+1)'(StackDepth))
    else $error("digit count exceeds stack depth");

  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_PUSH) |-> (rem < tgt_base))
    else $error("remainder not below target base");

  a_valid_in_wait: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (state == ST_WAIT))
    else $error("output word valid outside wait state");

  a_last_at_bottom: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (idx == '0))
    else $error("last word not at bottom of stack");
`endif

endmodule

>>> design/radix_text_converter.sv
// Each character word is accumulated in the back end once it leaves the input queue.
// A final word then runs the bit-serial divider once per target digit,
// then sends each digit out via the digit stack (read, load, wait), with output stalls.
// The input side keeps taking words into a 4-deep queue while the back end works.
// Synchronous active-high reset sets both bases to 10 and clears the accumulator.
module radix_text_converter #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] digit_char
  input  logic       s_tlast,   // is_final
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast,   // out_last
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data
);
  import rtc_pkg::*;

  logic [BaseW-1:0] source_base;
  logic [BaseW-1:0] target_base;
  logic             push;
  rtc_entry_t       push_data;
  logic             queue_full;
  logic             queue_empty;
  logic             pop;
  rtc_entry_t       pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= BASE_RESET;
      target_base <= BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_BASE: source_base <= cfg_data;
        REG_TARGET_BASE: target_base <= cfg_data;
        default: ;
      endcase
    end
  end

  rtc_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  rtc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  rtc_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_base     (clamp_base(source_base)),
    .tgt_base    (clamp_base(target_base)),
    .queue_empty (queue_empty),
    .entry       (pop_data),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

>>> verif/tb_radix_text_converter.sv
`timescale 1ns / 1ps

module tb_radix_text_converter;
  import rtc_pkg::*;

  localparam int VALUE_BITS    = 32;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_CHARS   = 40;

  typedef byte unsigned text_t[$];

  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
  } digit_word_t;

  typedef enum { ROW_CFG, ROW_CHAR } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              sel;
    logic [BaseW-1:0]  base;
    logic [CharW-1:0]  ch;
    logic              fin;
    string             typed;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;   // [7:0] digit_char
  logic             s_tlast = 1'b0; // is_final
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;        // [7:0] out_char
  logic             m_tlast;        // out_last
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [5:0]       cfg_data = '0;

  // Converter state as this bench sees it.
  logic [BaseW-1:0]      in_base_reg = BASE_RESET;
  logic [BaseW-1:0]      tgt_base_reg = BASE_RESET;
  logic [VALUE_BITS-1:0] acc_value = '0;

  digit_word_t expected_digits[$];
  int unsigned error_count = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  radix_text_converter #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned effective_base(logic [BaseW-1:0] b);
    return (b < BASE_MIN) ? BASE_MIN : ((b > BASE_MAX) ? BASE_MAX : b);
  endfunction

  function automatic int unsigned char_weight(logic [CharW-1:0] c);
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) return c - CHAR_ZERO;
    if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) return c - CHAR_LOWER_A + 10;
    if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) return c - CHAR_UPPER_A + 10;
    return 0;
  endfunction

  // Accumulates one character and, on a final one, returns the value written
  // in the target base, most significant digit first.
  function automatic text_t convert_char(logic [CharW-1:0] c, logic fin);
    text_t                 digits;
    logic [VALUE_BITS-1:0] rest;
    int unsigned           radix;
    int unsigned           d;
    acc_value = acc_value * effective_base(in_base_reg) + char_weight(c);
    if (!fin) return digits;
    radix = effective_base(tgt_base_reg);
    rest = acc_value;
    do begin
      d = rest % radix;
      // Only the least significant digits that fit the stack are kept.
      if (digits.size() < StackDepth)
        digits.push_front(8'(d < 10 ? CHAR_ZERO + d : CHAR_UPPER_A + d - 10));
      rest = rest / radix;
    end while (rest != 0);
    acc_value = '0;
    return digits;
  endfunction

  function automatic text_t text_of(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic void queue_text(text_t t);
    foreach (t[i]) expected_digits.push_back('{t[i], i == t.size() - 1});
  endfunction

  function automatic stim_row_t row_char(logic [CharW-1:0] c, logic fin, string typed);
    return '{ROW_CHAR, 1'b0, '0, c, fin, typed};
  endfunction

  function automatic stim_row_t row_cfg(logic sel, logic [BaseW-1:0] base);
    return '{ROW_CFG, sel, base, '0, 1'b0, ""};
  endfunction

  // Mostly digits that are legal in the source base, in either letter case,
  // with some arbitrary bytes mixed in.
  function automatic logic [CharW-1:0] pick_char(int unsigned radix);
    int unsigned d;
    if ($urandom_range(0, 99) < 12) return 8'($urandom_range(0, 255));
    d = $urandom_range(0, radix - 1);
    if (d < 10) return 8'(CHAR_ZERO + d);
    if ($urandom_range(0, 1) == 1) return 8'(CHAR_LOWER_A + d - 10);
    return 8'(CHAR_UPPER_A + d - 10);
  endfunction

  task automatic note_mismatch(string msg);
    $display("%0t ns: MISMATCH %s", $realtime, msg);
    error_count++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(logic sel, logic [BaseW-1:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_SOURCE_BASE) in_base_reg = val;
    else tgt_base_reg = val;
  endtask

  task automatic feed_char(logic [CharW-1:0] c, logic fin, string typed);
    text_t predicted;
    if (!calm && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= fin;
    do @(posedge clk); while (!s_tready);
    predicted = convert_char(c, fin);
    if (typed.len() > 0) queue_text(text_of(typed));
    else queue_text(predicted);
  endtask

  initial begin : result_sink
    digit_word_t want;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (expected_digits.size() == 0) begin
          note_mismatch($sformatf("unexpected word char=%h last=%b", m_tdata, m_tlast));
        end else begin
          want = expected_digits.pop_front();
          if (m_tdata !== want.ch)
            note_mismatch($sformatf("out_char got %h want %h", m_tdata, want.ch));
          if (m_tlast !== want.last)
            note_mismatch($sformatf("out_last got %b want %b", m_tlast, want.last));
        end
      end
      if (hold_req) begin
        // Hold the output off long enough that the input queue fills behind it.
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      m_tready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  initial begin : stimulus
    stim_row_t        stim_rows[$];
    int unsigned      sent;
    int unsigned      run_len;
    logic [BaseW-1:0] src_pick;
    logic [BaseW-1:0] tgt_pick;
    logic [CharW-1:0] c;
    logic             fin;

    stim_rows.push_back(row_char("7", 1'b1, "7"));
    stim_rows.push_back(row_char("0", 1'b1, "0"));
    stim_rows.push_back(row_char("2", 1'b0, ""));
    stim_rows.push_back(row_char("5", 1'b0, ""));
    stim_rows.push_back(row_char("5", 1'b1, "255"));
    // Bytes that are not digits weigh nothing.
    stim_rows.push_back(row_char("1", 1'b0, ""));
    stim_rows.push_back(row_char(8'h00, 1'b0, ""));
    stim_rows.push_back(row_char(8'hFF, 1'b1, "100"));
    // Letters beyond the base keep their value.
    stim_rows.push_back(row_char("z", 1'b1, "35"));
    stim_rows.push_back(row_char("Z", 1'b1, "35"));
    stim_rows.push_back(row_cfg(REG_SOURCE_BASE, 6'd16));
    stim_rows.push_back(row_cfg(REG_TARGET_BASE, 6'd16));
    stim_rows.push_back(row_char("F", 1'b0, ""));
    stim_rows.push_back(row_char("f", 1'b1, "FF"));
    // Out-of-range bases clamp to 2 and 36.
    stim_rows.push_back(row_cfg(REG_SOURCE_BASE, 6'd0));
    stim_rows.push_back(row_cfg(REG_TARGET_BASE, 6'd63));
    stim_rows.push_back(row_char("1", 1'b0, ""));
    stim_rows.push_back(row_char("1", 1'b1, "3"));
    stim_rows.push_back(row_char("z", 1'b0, ""));
    stim_rows.push_back(row_char("Z", 1'b1, ""));
    // Seven base-36 letters overflow the accumulator; binary output is long.
    stim_rows.push_back(row_cfg(REG_SOURCE_BASE, BASE_MAX));
    stim_rows.push_back(row_cfg(REG_TARGET_BASE, BASE_MIN));
    for (int i = 0; i < 7; i++) stim_rows.push_back(row_char("z", i == 6, ""));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) write_base(stim_rows[i].sel, stim_rows[i].base);
      else feed_char(stim_rows[i].ch, stim_rows[i].fin, stim_rows[i].typed);
    end

    for (int p = 0; p < PHASES; p++) begin
      unique case (p)
        0: begin
          src_pick = BASE_MIN;
          tgt_pick = BASE_MAX;
        end
        1: begin
          src_pick = BASE_MAX;
          tgt_pick = BASE_MIN;
        end
        2: begin
          src_pick = BASE_RESET;
          tgt_pick = BASE_RESET;
        end
        3: begin
          src_pick = 6'd16;
          tgt_pick = BASE_MIN;
        end
        default: begin
          src_pick = 6'($urandom_range(0, 63));
          tgt_pick = 6'($urandom_range(0, 63));
        end
      endcase
      write_base(REG_SOURCE_BASE, src_pick);
      write_base(REG_TARGET_BASE, tgt_pick);
      calm = (p == 2);
      if (p == 3) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_CHARS) begin
        run_len = $urandom_range(1, 8);
        for (int k = 0; k < run_len; k++) begin
          c = pick_char(effective_base(in_base_reg));
          // Now and then a number runs on without its final character.
          fin = (k == run_len - 1) && ($urandom_range(0, 9) != 0);
          feed_char(c, fin, "");
          sent++;
        end
      end
    end
    calm = 1'b0;

    wait_drained();
    if (error_count == 0) begin
      $display("tb_radix_text_converter: done, clean");
    end else begin
      $display("tb_radix_text_converter: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("tb_radix_text_converter: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
design/rtc_pkg.sv
design/rtc_front.sv
design/rtc_fifo.sv
design/rtc_back.sv
design/radix_text_converter.sv
verif/tb_radix_text_converter.sv
